FILE: rtl/sdci_pkg.sv
// ----------------------------------------------------------------------------
// sdci_pkg
// Types and constants shared by the SD card initialisation sequencer modules.
// ----------------------------------------------------------------------------
package sdci_pkg;

  // Sequencer phase, one-hot.
  typedef enum logic [8:0] {
    PH_IDLE = 9'b0_0000_0001,
    PH_CMD0 = 9'b0_0000_0010,
    PH_CMD8 = 9'b0_0000_0100,
    PH_A41  = 9'b0_0000_1000,
    PH_CMD2 = 9'b0_0001_0000,
    PH_CMD3 = 9'b0_0010_0000,
    PH_CMD9 = 9'b0_0100_0000,
    PH_CMD7 = 9'b0_1000_0000,
    PH_A6   = 9'b1_0000_0000
  } phase_e;

  // Result kinds.
  localparam logic [1:0] KIND_ISSUE = 2'd0;
  localparam logic [1:0] KIND_OK    = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  // Response types.
  localparam logic [1:0] RT_NONE  = 2'd0;
  localparam logic [1:0] RT_SHORT = 2'd1;
  localparam logic [1:0] RT_LONG  = 2'd2;

  // Command indices.
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_ALL_CID   = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
  localparam logic [5:0] CMD_BUS_WIDTH = 6'd6;
  localparam logic [5:0] CMD_SELECT    = 6'd7;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
  localparam logic [5:0] CMD_SEND_CID  = 6'd10;
  localparam logic [5:0] CMD_OP_COND   = 6'd41;
  localparam logic [5:0] CMD_APP       = 6'd55;

  // Command arguments.
  localparam logic [31:0] ARG_IF_COND   = 32'h0000_01AA;
  localparam logic [31:0] ARG_OP_COND   = 32'h0010_0000;
  localparam logic [31:0] ARG_BUS_WIDTH = 32'h0000_0002;
  localparam int unsigned HCS_BIT       = 30;

  // Error codes.
  localparam logic [3:0] ERR_NONE   = 4'd0;
  localparam logic [3:0] ERR_CMD0   = 4'd1;
  localparam logic [3:0] ERR_CMD8   = 4'd2;
  localparam logic [3:0] ERR_ACMD41 = 4'd3;
  localparam logic [3:0] ERR_CMD2   = 4'd4;
  localparam logic [3:0] ERR_CMD3   = 4'd5;
  localparam logic [3:0] ERR_CMD9   = 4'd6;
  localparam logic [3:0] ERR_CSD    = 4'd7;
  localparam logic [3:0] ERR_CMD7   = 4'd8;
  localparam logic [3:0] ERR_ACMD6  = 4'd9;

  // Register indices of the configuration port.
  localparam logic REG_MAX_TRIES = 1'b0;
  localparam logic REG_OP_TRIES  = 1'b1;

  localparam logic [7:0]  MAX_TRIES_RST = 8'd10;
  localparam logic [15:0] OP_TRIES_RST  = 16'd10000;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  try_count;
    logic [15:0] poll_count;
    logic        app_pending;
    logic        host_hc;
    logic        card_hc;
    logic [15:0] rca;
  } seq_state_t;

  typedef struct packed {
    logic        has;
    logic [1:0]  kind;
    logic [5:0]  idx;
    logic [31:0] arg;
    logic [1:0]  rt;
    logic [3:0]  err;
    logic        card_hc;
    logic [15:0] rca;
  } seq_res_t;

  typedef struct packed {
    logic [7:0]  max_tries;
    logic [15:0] op_tries;
  } seq_cfg_t;

  function automatic logic [1:0] resp_type(input logic [5:0] idx);
    logic [1:0] rt;
    rt = RT_SHORT;
    if (idx == CMD_GO_IDLE) begin
      rt = RT_NONE;
    end else if (idx == CMD_ALL_CID || idx == CMD_SEND_CSD || idx == CMD_SEND_CID) begin
      rt = RT_LONG;
    end
    return rt;
  endfunction

endpackage

FILE: rtl/sd_card_init_sequencer_unit.sv
// Pipeline: an accepted item is held in the input register, then its decision is
// written to the result register when that is free. Throughput: one item per cycle
// unless the output stalls; the sequencer state updates with each decision.
// Reset: rst_ni clears the sequencer to idle, both registers to empty and the
// configuration to 10 tries per command and 10000 ACMD41 polls.
// ----------------------------------------------------------------------------
// sd_card_init_sequencer_unit
// SD card bring-up sequencer: turns command completions into the next command.
// ----------------------------------------------------------------------------
module sd_card_init_sequencer_unit
  import sdci_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic        flag_timeout_i,
  input  logic        flag_resp_end_i,
  input  logic        flag_sent_i,
  input  logic        flag_crc_fail_i,
  input  logic [31:0] response_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [5:0]  cmd_index_o,
  output logic [31:0] cmd_arg_o,
  output logic [1:0]  resp_type_o,
  output logic [3:0]  error_code_o,
  output logic        power_off_o,
  output logic        wide_bus_o,
  output logic        high_capacity_o,
  output logic [15:0] card_address_o
);

  seq_cfg_t    cfg;
  seq_state_t  state_q;
  seq_state_t  state_d;
  seq_res_t    res_d;
  seq_res_t    res_q;
  logic        in_vld_q;
  logic        out_vld_q;
  logic        in_accept;
  logic        advance;
  logic        op_q;
  logic        fl_to_q;
  logic        fl_re_q;
  logic        fl_snt_q;
  logic        fl_crc_q;
  logic [31:0] resp_q;

  sdci_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sdci_step u_step (
    .cur_i           (state_q),
    .cfg_i           (cfg),
    .operation_i     (op_q),
    .flag_timeout_i  (fl_to_q),
    .flag_resp_end_i (fl_re_q),
    .flag_sent_i     (fl_snt_q),
    .flag_crc_fail_i (fl_crc_q),
    .response_i      (resp_q),
    .nxt_o           (state_d),
    .res_o           (res_d)
  );

  // The held item moves on once the result register is free or being emptied.
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{phase: PH_IDLE, default: '0};
    end else begin
      if (in_accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= res_d.has;
        state_q   <= state_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= operation_i;
      fl_to_q  <= flag_timeout_i;
      fl_re_q  <= flag_resp_end_i;
      fl_snt_q <= flag_sent_i;
      fl_crc_q <= flag_crc_fail_i;
      resp_q   <= response_i;
    end
    if (advance && res_d.has) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign kind_o          = res_q.kind;
  assign cmd_index_o     = res_q.idx;
  assign cmd_arg_o       = res_q.arg;
  assign resp_type_o     = res_q.rt;
  assign error_code_o    = res_q.err;
  assign power_off_o     = (res_q.kind == KIND_ERR);
  assign wide_bus_o      = (res_q.kind == KIND_OK);
  assign high_capacity_o = res_q.card_hc;
  assign card_address_o  = res_q.rca;

`ifndef SYNTHESIS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q)
    else $error("input stalled with no item held");

  a_finish_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d.has && res_d.kind != KIND_ISSUE) |=> (state_q.phase == PH_IDLE))
    else $error("sequencer not idle after a final result");

  a_busy_has_try: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase != PH_IDLE) |-> (state_q.try_count != 8'd0))
    else $error("active phase with zero try count");

  a_err_code_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((res_q.kind == KIND_ERR) == (res_q.err != ERR_NONE)))
    else $error("error code disagrees with result kind");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> (out_vld_q && $stable(res_q)))
    else $error("stalled result changed");
`endif

endmodule

FILE: rtl/sdci_apb.sv
// ----------------------------------------------------------------------------
// sdci_apb
// Configuration registers of the sequencer behind a simple APB slave.
// ----------------------------------------------------------------------------
module sdci_apb
  import sdci_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output seq_cfg_t    cfg_o
);

  logic [7:0]  max_tries_q;
  logic [15:0] op_tries_q;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tries_q <= MAX_TRIES_RST;
      op_tries_q  <= OP_TRIES_RST;
    end else if (wr_en) begin
      if (reg_sel == REG_MAX_TRIES) begin
        max_tries_q <= pwdata[7:0];
      end else begin
        op_tries_q <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MAX_TRIES: prdata = {24'd0, max_tries_q};
      REG_OP_TRIES:  prdata = {16'd0, op_tries_q};
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.max_tries = max_tries_q;
  assign cfg_o.op_tries  = op_tries_q;

endmodule

FILE: rtl/sdci_step.sv
// ----------------------------------------------------------------------------
// sdci_step
// Decision logic: classifies one command completion and picks the next
// command or the final result, together with the next sequencer state.
// ----------------------------------------------------------------------------
module sdci_step
  import sdci_pkg::*;
(
  input  seq_state_t  cur_i,
  input  seq_cfg_t    cfg_i,
  input  logic        operation_i,
  input  logic        flag_timeout_i,
  input  logic        flag_resp_end_i,
  input  logic        flag_sent_i,
  input  logic        flag_crc_fail_i,
  input  logic [31:0] response_i,
  output seq_state_t  nxt_o,
  output seq_res_t    res_o
);

  typedef enum logic [1:0] {
    OUT_TIMEOUT = 2'd0,
    OUT_OK      = 2'd1,
    OUT_CRC     = 2'd2,
    OUT_UNKNOWN = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ISSUE,
    ACT_BEGIN,
    ACT_AGAIN,
    ACT_FINISH,
    ACT_A41_INNER,
    ACT_A41_OUTER,
    ACT_A6_INNER
  } act_e;

  outcome_e    outcome;
  act_e        act;
  phase_e      a_phase;
  logic [5:0]  a_idx;
  logic [31:0] a_arg;
  logic [3:0]  a_err;
  logic [7:0]  eff_max;
  logic        try_lt;
  logic        poll_lt;
  logic        go_outer;
  logic [31:0] rca_arg;
  seq_state_t  nxt;
  seq_res_t    res;

  assign eff_max = (cfg_i.max_tries == 8'd0) ? 8'd1 : cfg_i.max_tries;

  always_comb begin
    priority if (flag_timeout_i) begin
      outcome = OUT_TIMEOUT;
    end else if (flag_resp_end_i || flag_sent_i) begin
      outcome = OUT_OK;
    end else if (flag_crc_fail_i) begin
      outcome = OUT_CRC;
    end else begin
      outcome = OUT_UNKNOWN;
    end
  end

  always_comb begin
    nxt      = cur_i;
    res      = '0;
    act      = ACT_NONE;
    a_phase  = PH_IDLE;
    a_idx    = CMD_GO_IDLE;
    a_arg    = '0;
    a_err    = ERR_NONE;
    go_outer = 1'b0;
    rca_arg  = {cur_i.rca, 16'd0};

    if (!operation_i) begin
      nxt.host_hc     = 1'b0;
      nxt.card_hc     = 1'b0;
      nxt.rca         = '0;
      nxt.poll_count  = '0;
      nxt.app_pending = 1'b0;
      act             = ACT_BEGIN;
      a_phase         = PH_CMD0;
    end else begin
      unique case (cur_i.phase)
        PH_IDLE: act = ACT_NONE;
        PH_CMD0: begin
          if (outcome == OUT_OK) begin
            act     = ACT_BEGIN;
            a_phase = PH_CMD8;
            a_idx   = CMD_IF_COND;
            a_arg   = ARG_IF_COND;
          end else begin
            act   = ACT_AGAIN;
            a_err = ERR_CMD0;
          end
        end
        PH_CMD8: begin
          a_err = ERR_CMD8;
          if (outcome == OUT_OK) begin
            if (response_i != ARG_IF_COND) begin
              act = ACT_FINISH;
            end else begin
              nxt.host_hc    = 1'b1;
              nxt.poll_count = '0;
              act            = ACT_A41_OUTER;
            end
          end else if (cur_i.try_count < eff_max) begin
            act   = ACT_AGAIN;
            a_idx = CMD_IF_COND;
            a_arg = ARG_IF_COND;
          end else if (outcome == OUT_TIMEOUT) begin
            // Old cards do not answer CMD8; carry on as a standard-capacity host.
            nxt.host_hc    = 1'b0;
            nxt.poll_count = '0;
            act            = ACT_A41_OUTER;
          end else begin
            act = ACT_FINISH;
          end
        end
        PH_A41: begin
          if (cur_i.app_pending) begin
            if (outcome == OUT_OK) begin
              nxt.app_pending = 1'b0;
              act             = ACT_ISSUE;
              a_idx           = CMD_OP_COND;
              a_arg           = ARG_OP_COND | ({31'd0, cur_i.host_hc} << HCS_BIT);
            end else begin
              act = ACT_A41_INNER;
            end
          end else if (outcome == OUT_CRC) begin
            // R3 carries no valid CRC, so a CRC failure is the normal answer.
            if (response_i[31]) begin
              nxt.card_hc = response_i[30];
              act         = ACT_BEGIN;
              a_phase     = PH_CMD2;
              a_idx       = CMD_ALL_CID;
            end else begin
              act = ACT_A41_OUTER;
            end
          end else begin
            act = ACT_A41_INNER;
          end
        end
        PH_CMD2: begin
          if (outcome == OUT_OK) begin
            act     = ACT_BEGIN;
            a_phase = PH_CMD3;
            a_idx   = CMD_SEND_RCA;
          end else begin
            act   = ACT_AGAIN;
            a_idx = CMD_ALL_CID;
            a_err = ERR_CMD2;
          end
        end
        PH_CMD3: begin
          act   = ACT_AGAIN;
          a_idx = CMD_SEND_RCA;
          a_err = ERR_CMD3;
          if (outcome == OUT_OK) begin
            nxt.rca = response_i[31:16];
            if (response_i[31:16] != 16'd0) begin
              act     = ACT_BEGIN;
              a_phase = PH_CMD9;
              a_idx   = CMD_SEND_CSD;
              a_arg   = {response_i[31:16], 16'd0};
            end
          end
        end
        PH_CMD9: begin
          if (outcome == OUT_OK) begin
            if (response_i[31:30] > 2'd1) begin
              act   = ACT_FINISH;
              a_err = ERR_CSD;
            end else begin
              act     = ACT_BEGIN;
              a_phase = PH_CMD7;
              a_idx   = CMD_SELECT;
              a_arg   = rca_arg;
            end
          end else begin
            act   = ACT_AGAIN;
            a_idx = CMD_SEND_CSD;
            a_arg = rca_arg;
            a_err = ERR_CMD9;
          end
        end
        PH_CMD7: begin
          if (outcome == OUT_OK) begin
            nxt.app_pending = 1'b1;
            act             = ACT_BEGIN;
            a_phase         = PH_A6;
            a_idx           = CMD_APP;
            a_arg           = rca_arg;
          end else begin
            act   = ACT_AGAIN;
            a_idx = CMD_SELECT;
            a_arg = rca_arg;
            a_err = ERR_CMD7;
          end
        end
        PH_A6: begin
          if (cur_i.app_pending && outcome == OUT_OK) begin
            nxt.app_pending = 1'b0;
            act             = ACT_ISSUE;
            a_idx           = CMD_BUS_WIDTH;
            a_arg           = ARG_BUS_WIDTH;
          end else if (!cur_i.app_pending && outcome == OUT_OK) begin
            act   = ACT_FINISH;
            a_err = ERR_NONE;
          end else begin
            act = ACT_A6_INNER;
          end
        end
        default: begin
          nxt.phase = PH_IDLE;
          act       = ACT_NONE;
        end
      endcase
    end

    try_lt  = nxt.try_count < eff_max;
    poll_lt = nxt.poll_count < cfg_i.op_tries;

    unique case (act)
      ACT_NONE: res.has = 1'b0;
      ACT_ISSUE: begin
        res.has = 1'b1;
        res.idx = a_idx;
        res.arg = a_arg;
      end
      ACT_BEGIN: begin
        nxt.phase     = a_phase;
        nxt.try_count = 8'd1;
        res.has       = 1'b1;
        res.idx       = a_idx;
        res.arg       = a_arg;
      end
      ACT_AGAIN: begin
        if (try_lt) begin
          nxt.try_count = nxt.try_count + 8'd1;
          res.has       = 1'b1;
          res.idx       = a_idx;
          res.arg       = a_arg;
        end else begin
          res.has = 1'b1;
          res.err = a_err;
        end
      end
      ACT_FINISH: begin
        res.has = 1'b1;
        res.err = a_err;
      end
      ACT_A41_INNER: begin
        if (try_lt) begin
          nxt.try_count   = nxt.try_count + 8'd1;
          nxt.app_pending = 1'b1;
          res.has         = 1'b1;
          res.idx         = CMD_APP;
          res.arg         = rca_arg;
        end else begin
          go_outer = 1'b1;
        end
      end
      ACT_A41_OUTER: go_outer = 1'b1;
      ACT_A6_INNER: begin
        if (try_lt) begin
          nxt.try_count   = nxt.try_count + 8'd1;
          nxt.app_pending = 1'b1;
          res.has         = 1'b1;
          res.idx         = CMD_APP;
          res.arg         = rca_arg;
        end else begin
          res.has = 1'b1;
          res.err = ERR_ACMD6;
        end
      end
      default: res.has = 1'b0;
    endcase

    // A fresh outer ACMD41 attempt restarts the CMD55 prefix retries.
    if (go_outer) begin
      res.has = 1'b1;
      if (poll_lt) begin
        nxt.poll_count  = nxt.poll_count + 16'd1;
        nxt.phase       = PH_A41;
        nxt.try_count   = 8'd1;
        nxt.app_pending = 1'b1;
        res.idx         = CMD_APP;
        res.arg         = rca_arg;
      end else begin
        res.err = ERR_ACMD41;
      end
    end

    // Any result that is not a command ends the sequence.
    if (res.has && (act == ACT_FINISH || (act != ACT_ISSUE && act != ACT_BEGIN
        && res.idx == CMD_GO_IDLE && res.arg == 32'd0 && !(act == ACT_AGAIN && try_lt)))) begin
      nxt.phase       = PH_IDLE;
      nxt.app_pending = 1'b0;
      res.kind        = (res.err == ERR_NONE) ? KIND_OK : KIND_ERR;
    end else begin
      res.kind = KIND_ISSUE;
    end

    res.rt      = (res.kind == KIND_ISSUE) ? resp_type(res.idx) : RT_NONE;
    res.card_hc = nxt.card_hc;
    res.rca     = nxt.rca;
  end

  assign nxt_o = nxt;
  assign res_o = res;

endmodule
